/* hdl/mbi_pkg.sv */
// Shared constants and types for the power-2 Mandelbulb iteration block.
// No dependencies; imported by mbi_front, mbi_back, the top level, the checks and the bench.
package mbi_pkg;

    localparam int COORD_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF   = 16;
    localparam int DE_W            = 48;
    localparam int RAD_W           = 32;
    localparam int DIGIT_W         = 16;   // multiplier digit, one digit per stage
    localparam int QUEUE_DEPTH     = 4;

    // sign information picked up by the front end
    typedef struct packed {
        logic nx;
        logic ny;
        logic nz;
        logic z_nz;
    } mbi_sign_t;

endpackage

/* hdl/mbi_dly.sv */
// Enabled delay line, D stages of W bits.
// No dependencies.
module mbi_dly #(
    parameter int W = 1,
    parameter int D = 1
) (
    input  logic         aclk,
    input  logic         en,
    input  logic [W-1:0] din,
    output logic [W-1:0] dout
);

    logic [W-1:0] sr_reg [D];

    always_ff @(posedge aclk) begin
        if (en) begin
            sr_reg[0] <= din;
            for (int i = 1; i < D; i++) begin
                sr_reg[i] <= sr_reg[i-1];
            end
        end
    end

    assign dout = sr_reg[D-1];

endmodule

/* hdl/mbi_mul.sv */
// Pipelined unsigned multiplier, one DW-bit digit of b per stage.
// Depends on nothing.
module mbi_mul #(
    parameter int WA = 32,
    parameter int WB = 32,
    parameter int DW = 16
) (
    input  logic             aclk,
    input  logic             en,
    input  logic [WA-1:0]    a,
    input  logic [WB-1:0]    b,
    output logic [WA+WB-1:0] p
);

    localparam int NS  = (WB + DW - 1) / DW;
    localparam int WBP = NS * DW;
    localparam int WP  = WA + WB;

    logic [WA-1:0]  a_reg [NS];
    logic [WBP-1:0] b_reg [NS];
    logic [WP-1:0]  p_reg [NS];

    for (genvar g = 0; g < NS; g++) begin : g_st
        logic [WA-1:0]    a_in;
        logic [WBP-1:0]   b_in;
        logic [WP-1:0]    p_in;
        logic [WA+DW-1:0] pp;
        if (g == 0) begin : g_first
            assign a_in = a;
            assign b_in = WBP'(b);
            assign p_in = '0;
        end else begin : g_next
            assign a_in = a_reg[g-1];
            assign b_in = b_reg[g-1];
            assign p_in = p_reg[g-1];
        end
        assign pp = a_in * b_in[g*DW +: DW];
        always_ff @(posedge aclk) begin
            if (en) begin
                a_reg[g] <= a_in;
                b_reg[g] <= b_in;
                p_reg[g] <= p_in + (WP'(pp) << (g * DW));
            end
        end
    end

    assign p = p_reg[NS-1];

endmodule

/* hdl/mbi_div.sv */
// Pipelined restoring divider: K quotient bits of n / d, one bit per stage.
// ovf flags a quotient of 2^K or more. No dependencies.
module mbi_div #(
    parameter int WN = 128,
    parameter int WD = 64,
    parameter int K  = 48
) (
    input  logic          aclk,
    input  logic          en,
    input  logic [WN-1:0] n,
    input  logic [WD-1:0] d,
    output logic [K-1:0]  q,
    output logic          ovf
);

    localparam int WH = WN - K;
    localparam int WC = (WH > WD) ? WH : WD;

    logic [WD-1:0] rem_reg [K+1];
    logic [K-1:0]  lo_reg  [K+1];
    logic [K-1:0]  q_reg   [K+1];
    logic [WD-1:0] d_reg   [K+1];
    logic          ovf_reg [K+1];

    // upper part must already be below d, otherwise the quotient does not fit
    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg[0] <= WD'(n[WN-1:K]);
            lo_reg[0]  <= n[K-1:0];
            q_reg[0]   <= '0;
            d_reg[0]   <= d;
            ovf_reg[0] <= WC'(n[WN-1:K]) >= WC'(d);
        end
    end

    for (genvar g = 1; g <= K; g++) begin : g_st
        logic [WD:0] tr;
        logic [WD:0] df;
        logic        ge;
        assign tr = {rem_reg[g-1], lo_reg[g-1][K-1]};
        assign ge = tr >= {1'b0, d_reg[g-1]};
        assign df = tr - {1'b0, d_reg[g-1]};
        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[g] <= ge ? df[WD-1:0] : tr[WD-1:0];
                lo_reg[g]  <= lo_reg[g-1] << 1;
                q_reg[g]   <= {q_reg[g-1][K-2:0], ge};
                d_reg[g]   <= d_reg[g-1];
                ovf_reg[g] <= ovf_reg[g-1];
            end
        end
    end

    assign q   = q_reg[K];
    assign ovf = ovf_reg[K];

endmodule

/* hdl/mbi_sqrt.sv */
// Pipelined integer square root, one result bit per stage.
// No dependencies.
module mbi_sqrt #(
    parameter int WO = 32
) (
    input  logic            aclk,
    input  logic            en,
    input  logic [2*WO-1:0] v,
    output logic [WO-1:0]   root
);

    logic [WO-1:0]   root_reg [WO];
    logic [WO+1:0]   rem_reg  [WO];
    logic [2*WO-1:0] v_reg    [WO];

    for (genvar g = 0; g < WO; g++) begin : g_st
        logic [WO-1:0]   root_in;
        logic [WO+1:0]   rem_in;
        logic [2*WO-1:0] v_in;
        logic [WO+3:0]   r2;
        logic [WO+3:0]   trial;
        logic [WO+3:0]   df;
        logic            ge;
        if (g == 0) begin : g_first
            assign root_in = '0;
            assign rem_in  = '0;
            assign v_in    = v;
        end else begin : g_next
            assign root_in = root_reg[g-1];
            assign rem_in  = rem_reg[g-1];
            assign v_in    = v_reg[g-1];
        end
        assign r2    = {rem_in, v_in[2*WO-1 -: 2]};
        assign trial = {2'b00, root_in, 2'b01};
        assign ge    = r2 >= trial;
        assign df    = r2 - trial;
        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[g]  <= ge ? df[WO+1:0] : r2[WO+1:0];
                root_reg[g] <= {root_in[WO-2:0], ge};
                v_reg[g]    <= v_in << 2;
            end
        end
    end

    assign root = root_reg[WO-1];

endmodule

/* hdl/mbi_front.sv */
// Front end: splits signed coordinates into magnitude and sign.
// Depends on mbi_pkg.
module mbi_front import mbi_pkg::*; #(
    parameter int CW = COORD_WIDTH_DEF
) (
    input  logic [CW-1:0] in_x,
    input  logic [CW-1:0] in_y,
    input  logic [CW-1:0] in_z,
    output logic [CW-1:0] mx,
    output logic [CW-1:0] my,
    output logic [CW-1:0] mz,
    output mbi_sign_t     sgn
);

    // the most negative code maps to 2^(CW-1), which still fits unsigned
    assign mx = in_x[CW-1] ? (~in_x + 1'b1) : in_x;
    assign my = in_y[CW-1] ? (~in_y + 1'b1) : in_y;
    assign mz = in_z[CW-1] ? (~in_z + 1'b1) : in_z;

    assign sgn.nx   = in_x[CW-1];
    assign sgn.ny   = in_y[CW-1];
    assign sgn.nz   = in_z[CW-1];
    assign sgn.z_nz = in_z != '0;

endmodule

/* hdl/mbi_queue.sv */
// Small flip-flop queue between front end and arithmetic back end.
// No dependencies.
module mbi_queue #(
    parameter int W     = 8,
    parameter int DEPTH = 4
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         push,
    input  logic [W-1:0] din,
    output logic         full,
    input  logic         pop,
    output logic [W-1:0] dout,
    output logic         empty
);

    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNTW = $clog2(DEPTH + 1);

    logic [W-1:0]    mem_reg [DEPTH];
    logic [AW-1:0]   wr_reg, wr_next;
    logic [AW-1:0]   rd_reg, rd_next;
    logic [CNTW-1:0] cnt_reg, cnt_next;
    logic            do_push, do_pop;

    assign full    = cnt_reg == CNTW'(DEPTH);
    assign empty   = cnt_reg == '0;
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign dout    = mem_reg[rd_reg];

    always_comb begin
        wr_next  = wr_reg;
        rd_next  = rd_reg;
        cnt_next = cnt_reg;
        if (do_push) begin
            wr_next = (wr_reg == AW'(DEPTH - 1)) ? '0 : wr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_next = (rd_reg == AW'(DEPTH - 1)) ? '0 : rd_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_reg] <= din;
        end
    end

endmodule

/* hdl/mbi_back.sv */
// Back end: squares, sums, wide products, divisions, square root, saturation
// and the output register. Depends on mbi_pkg, mbi_mul, mbi_div, mbi_sqrt, mbi_dly.
module mbi_back import mbi_pkg::*; #(
    parameter int CW = COORD_WIDTH_DEF,
    parameter int FB = FRAC_BITS_DEF
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_valid,
    input  logic [CW-1:0]    mx,
    input  logic [CW-1:0]    my,
    input  logic [CW-1:0]    mz,
    input  logic [DE_W-1:0]  d,
    input  logic [RAD_W-1:0] r,
    input  mbi_sign_t        sgn,
    output logic             take,
    output logic             m_valid,
    input  logic             m_ready,
    output logic [CW-1:0]    out_x,
    output logic [CW-1:0]    out_y,
    output logic [CW-1:0]    out_z,
    output logic [DE_W-1:0]  de_out,
    output logic             on_axis,
    output logic             clipped
);

    localparam int K   = CW + FB;
    localparam int W2  = 2 * CW;
    localparam int W4  = 4 * CW;
    localparam int WDP = DE_W + RAD_W;
    localparam int L1  = (CW + DIGIT_W - 1) / DIGIT_W;
    localparam int L2  = (W2 + DIGIT_W - 1) / DIGIT_W;
    localparam int LDE = (RAD_W + DIGIT_W - 1) / DIGIT_W;
    localparam int LD  = L1 + 2 + L2 + K + 1;

    logic            adv;
    logic [LD-1:0]   vld_reg;

    logic [W2-1:0]   x2, y2, z2, xy;
    logic [WDP-1:0]  dp;
    logic [W2-1:0]   s_p1_reg, q_p1_reg, z2_p1_reg, xy2_p1_reg;
    logic            nq_p1_reg;
    logic [W2-1:0]   s_p2_reg, q_p2_reg, z2_p2_reg, xy2_p2_reg, dif_p2_reg;
    logic            nq_p2_reg, nd_p2_reg, onax_p2_reg;
    logic [W4-1:0]   n1, n2, t;
    logic [W2-1:0]   s_d;
    logic [K-1:0]    qx, qy;
    logic            ovx, ovy;
    logic [CW-1:0]   root, root_d;
    logic            ovz_d;
    logic [2:0]      flg_d;
    mbi_sign_t       sgn_d;
    logic            de_big, de_big_d;
    logic [DE_W-1:0] de_v, de_v_d;
    logic            sx, sy, sz;
    logic [CW:0]     rx, ry, rz;

    logic            m_valid_reg;
    logic [CW-1:0]   out_x_reg, out_y_reg, out_z_reg;
    logic [DE_W-1:0] de_out_reg;
    logic            on_axis_reg, clipped_reg;

    // returns {clip, code}: magnitude clamped to the signed range, sign applied
    function automatic logic [CW:0] sat_coord(input logic ovf, input logic [CW-1:0] mag,
                                              input logic neg);
        logic [CW-1:0] lim;
        logic [CW-1:0] v;
        logic          c;
        lim = neg ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
        c   = ovf || (mag > lim);
        v   = c ? lim : mag;
        return {c, neg ? (~v + 1'b1) : v};
    endfunction

    assign adv  = !m_valid_reg || m_ready;
    assign take = adv;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (adv) begin
            vld_reg <= {vld_reg[LD-2:0], in_valid};
        end
    end

    mbi_mul #(.WA(CW), .WB(CW), .DW(DIGIT_W)) u_x2 (.aclk, .en(adv), .a(mx), .b(mx), .p(x2));
    mbi_mul #(.WA(CW), .WB(CW), .DW(DIGIT_W)) u_y2 (.aclk, .en(adv), .a(my), .b(my), .p(y2));
    mbi_mul #(.WA(CW), .WB(CW), .DW(DIGIT_W)) u_z2 (.aclk, .en(adv), .a(mz), .b(mz), .p(z2));
    mbi_mul #(.WA(CW), .WB(CW), .DW(DIGIT_W)) u_xy (.aclk, .en(adv), .a(mx), .b(my), .p(xy));
    mbi_mul #(.WA(DE_W), .WB(RAD_W), .DW(DIGIT_W)) u_de (
        .aclk, .en(adv), .a(d), .b(r), .p(dp)
    );

    // s = x^2 + y^2 cannot carry out: both squares are at most 2^(2CW-2)
    always_ff @(posedge aclk) begin
        if (adv) begin
            s_p1_reg   <= x2 + y2;
            nq_p1_reg  <= x2 < y2;
            q_p1_reg   <= (x2 < y2) ? (y2 - x2) : (x2 - y2);
            z2_p1_reg  <= z2;
            xy2_p1_reg <= {xy[W2-2:0], 1'b0};
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            s_p2_reg    <= s_p1_reg;
            nd_p2_reg   <= s_p1_reg < z2_p1_reg;
            dif_p2_reg  <= (s_p1_reg < z2_p1_reg) ? (z2_p1_reg - s_p1_reg)
                                                  : (s_p1_reg - z2_p1_reg);
            q_p2_reg    <= q_p1_reg;
            nq_p2_reg   <= nq_p1_reg;
            z2_p2_reg   <= z2_p1_reg;
            xy2_p2_reg  <= xy2_p1_reg;
            onax_p2_reg <= s_p1_reg == '0;
        end
    end

    mbi_mul #(.WA(W2), .WB(W2), .DW(DIGIT_W)) u_n1 (
        .aclk, .en(adv), .a(q_p2_reg), .b(dif_p2_reg), .p(n1)
    );
    mbi_mul #(.WA(W2), .WB(W2), .DW(DIGIT_W)) u_n2 (
        .aclk, .en(adv), .a(xy2_p2_reg), .b(dif_p2_reg), .p(n2)
    );
    mbi_mul #(.WA(W2), .WB(W2), .DW(DIGIT_W)) u_t (
        .aclk, .en(adv), .a(z2_p2_reg), .b(s_p2_reg), .p(t)
    );
    mbi_dly #(.W(W2), .D(L2)) u_sdly (.aclk, .en(adv), .din(s_p2_reg), .dout(s_d));

    // floor(n / (s * 2^FB)) is taken as floor(n / s) with FB more quotient bits
    mbi_div #(.WN(W4), .WD(W2), .K(K)) u_dx (.aclk, .en(adv), .n(n1), .d(s_d), .q(qx), .ovf(ovx));
    mbi_div #(.WN(W4), .WD(W2), .K(K)) u_dy (.aclk, .en(adv), .n(n2), .d(s_d), .q(qy), .ovf(ovy));

    // sqrt(4 z^2 s) / 2^FB = isqrt(z^2 s >> (2FB - 2)) is taken on the scaled value
    mbi_sqrt #(.WO(CW)) u_sq (
        .aclk, .en(adv), .v(W2'((t << 2) >> (2 * FB))), .root(root)
    );
    mbi_dly #(.W(1), .D(K + 1)) u_ovz (
        .aclk, .en(adv), .din(((t << 2) >> (W2 + 2 * FB)) != '0), .dout(ovz_d)
    );
    mbi_dly #(.W(CW), .D(FB + 1)) u_rdly (.aclk, .en(adv), .din(root), .dout(root_d));

    mbi_dly #(.W(3), .D(L2 + K + 1)) u_fdly (
        .aclk, .en(adv), .din({nq_p2_reg, nd_p2_reg, onax_p2_reg}), .dout(flg_d)
    );
    mbi_dly #(.W($bits(mbi_sign_t)), .D(LD)) u_sgdly (
        .aclk, .en(adv), .din(sgn), .dout(sgn_d)
    );

    // de * 2 * r in Q.FB: product shifted right by FB - 1
    assign de_big = (dp >> (FB - 1 + DE_W)) != '0;
    assign de_v   = de_big ? {DE_W{1'b1}} : DE_W'(dp >> (FB - 1));
    mbi_dly #(.W(DE_W + 1), .D(LD - LDE)) u_dedly (
        .aclk, .en(adv), .din({de_big, de_v}), .dout({de_big_d, de_v_d})
    );

    assign sx = flg_d[2] ^ flg_d[1];
    assign sy = sgn_d.nx ^ sgn_d.ny ^ flg_d[1];
    assign sz = sgn_d.z_nz && !sgn_d.nz;
    assign rx = sat_coord(ovx, qx[K-1:FB], sx);
    assign ry = sat_coord(ovy, qy[K-1:FB], sy);
    assign rz = sat_coord(ovz_d, root_d, sz);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (adv) begin
            m_valid_reg <= vld_reg[LD-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            de_out_reg  <= de_v_d;
            on_axis_reg <= flg_d[0];
            if (flg_d[0]) begin
                out_x_reg   <= '0;
                out_y_reg   <= '0;
                out_z_reg   <= '0;
                clipped_reg <= de_big_d;
            end else begin
                out_x_reg   <= rx[CW-1:0];
                out_y_reg   <= ry[CW-1:0];
                out_z_reg   <= rz[CW-1:0];
                clipped_reg <= de_big_d || rx[CW] || ry[CW] || rz[CW];
            end
        end
    end

    assign m_valid = m_valid_reg;
    assign out_x   = out_x_reg;
    assign out_y   = out_y_reg;
    assign out_z   = out_z_reg;
    assign de_out  = de_out_reg;
    assign on_axis = on_axis_reg;
    assign clipped = clipped_reg;

endmodule

/* hdl/mandelbulb_power2_iteration_top.sv */
// Throughput: one item per cycle, stalling only while m_tvalid is high and m_tready is low.
// Reset: synchronous active-low aresetn empties the queue and the pipeline valids.
// Depends on mbi_pkg, mbi_front, mbi_queue, mbi_back.
module mandelbulb_power2_iteration_top import mbi_pkg::*; #(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF,
    parameter int FRAC_BITS   = FRAC_BITS_DEF,
    localparam int IN_W  = ((3 * COORD_WIDTH + DE_W + RAD_W + 7) / 8) * 8,
    localparam int OUT_W = ((3 * COORD_WIDTH + DE_W + 7) / 8) * 8
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [IN_W-1:0]  s_tdata,   // in_x, in_y, in_z, de_in, radius, zero pad
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [OUT_W-1:0] m_tdata,   // out_x, out_y, out_z, de_out, zero pad
    output logic [1:0]       m_tuser    // on_axis, clipped
);

    localparam int CW = COORD_WIDTH;
    localparam int QW = 3 * CW + DE_W + RAD_W + $bits(mbi_sign_t);

    logic [CW-1:0]    f_mx, f_my, f_mz;
    mbi_sign_t        f_sgn;
    logic             q_full, q_empty, take;
    logic [QW-1:0]    q_dout;
    logic [CW-1:0]    b_mx, b_my, b_mz;
    logic [DE_W-1:0]  b_d;
    logic [RAD_W-1:0] b_r;
    mbi_sign_t        b_sgn;
    logic [CW-1:0]    o_x, o_y, o_z;
    logic [DE_W-1:0]  o_de;
    logic             o_axis, o_clip;

    mbi_front #(.CW(CW)) u_front (
        .in_x (s_tdata[CW-1:0]),
        .in_y (s_tdata[2*CW-1:CW]),
        .in_z (s_tdata[3*CW-1:2*CW]),
        .mx   (f_mx),
        .my   (f_my),
        .mz   (f_mz),
        .sgn  (f_sgn)
    );

    mbi_queue #(.W(QW), .DEPTH(QUEUE_DEPTH)) u_queue (
        .aclk,
        .aresetn,
        .push  (s_tvalid),
        .din   ({f_sgn, s_tdata[3*CW+DE_W +: RAD_W], s_tdata[3*CW +: DE_W], f_mz, f_my, f_mx}),
        .full  (q_full),
        .pop   (take),
        .dout  (q_dout),
        .empty (q_empty)
    );

    assign s_tready = !q_full;
    assign {b_sgn, b_r, b_d, b_mz, b_my, b_mx} = q_dout;

    mbi_back #(.CW(CW), .FB(FRAC_BITS)) u_back (
        .aclk,
        .aresetn,
        .in_valid (!q_empty),
        .mx       (b_mx),
        .my       (b_my),
        .mz       (b_mz),
        .d        (b_d),
        .r        (b_r),
        .sgn      (b_sgn),
        .take     (take),
        .m_valid  (m_tvalid),
        .m_ready  (m_tready),
        .out_x    (o_x),
        .out_y    (o_y),
        .out_z    (o_z),
        .de_out   (o_de),
        .on_axis  (o_axis),
        .clipped  (o_clip)
    );

    assign m_tdata = OUT_W'({o_de, o_z, o_y, o_x});
    assign m_tuser = {o_clip, o_axis};

endmodule

/* hdl/mbi_check.sv */
// Port-level checks for the Mandelbulb iteration block, bound to the top level.
// Depends on mbi_pkg and mandelbulb_power2_iteration_top.
module mbi_check import mbi_pkg::*; #(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF,
    localparam int IN_W  = ((3 * COORD_WIDTH + DE_W + RAD_W + 7) / 8) * 8,
    localparam int OUT_W = ((3 * COORD_WIDTH + DE_W + 7) / 8) * 8
) (
    input logic             aclk,
    input logic             aresetn,
    input logic             s_tvalid,
    input logic             s_tready,
    input logic [IN_W-1:0]  s_tdata,    // in_x, in_y, in_z, de_in, radius, zero pad
    input logic             m_tvalid,
    input logic             m_tready,
    input logic [OUT_W-1:0] m_tdata,    // out_x, out_y, out_z, de_out, zero pad
    input logic [1:0]       m_tuser     // on_axis, clipped
);

    localparam int CW = COORD_WIDTH;

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    a_reset: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    a_axis_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> m_tdata[3*CW-1:0] == '0)
        else $error("on-axis result with nonzero coordinates");

    a_axis_clip: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] && (m_tdata[3*CW +: DE_W] != {DE_W{1'b1}}) |-> !m_tuser[1])
        else $error("on-axis result clipped without derivative saturation");

endmodule

bind mandelbulb_power2_iteration_top mbi_check #(.COORD_WIDTH(COORD_WIDTH)) u_check (.*);

/* tb/tb_mandelbulb_power2_iteration_top.sv */
// Self-checking bench for the power-2 Mandelbulb iteration block: point items in,
// predicted iteration results compared item by item. Depends on mbi_pkg and the RTL top.
module tb_mandelbulb_power2_iteration_top;
    import mbi_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CW       = COORD_WIDTH_DEF;
    localparam int FB       = FRAC_BITS_DEF;
    localparam int IN_W     = 3 * CW + DE_W + RAD_W;
    localparam int OUT_W    = 3 * CW + DE_W;
    localparam int N_RAND   = 1100;
    localparam int IDLE_PCT = 36;
    localparam int STALL_LIMIT = 5000;

    typedef logic [255:0] wide_t;

    typedef struct packed {
        logic [RAD_W-1:0] rad;
        logic [DE_W-1:0]  de;
        logic [CW-1:0]    z;
        logic [CW-1:0]    y;
        logic [CW-1:0]    x;
    } point_t;

    typedef struct packed {
        logic [CW-1:0]   x;
        logic [CW-1:0]   y;
        logic [CW-1:0]   z;
        logic [DE_W-1:0] de;
        logic            on_axis;
        logic            clipped;
    } iter_t;

    class iter_scoreboard;
        iter_t expected_q[$];
        int    errors;
        logic  clip_hit;

        function wide_t magnitude(logic [CW-1:0] v);
            logic [CW-1:0] m;
            m = v[CW-1] ? -v : v;
            return wide_t'(m);
        endfunction

        function wide_t isqrt(wide_t n);
            wide_t r, t;
            r = '0;
            for (int i = 127; i >= 0; i--) begin
                t = r | (wide_t'(1) << i);
                if (t * t <= n) r = t;
            end
            return r;
        endfunction

        function logic [CW-1:0] saturate(wide_t mag, logic neg);
            wide_t lim;
            lim = neg ? (wide_t'(1) << (CW - 1)) : (wide_t'(1) << (CW - 1)) - 1;
            if (mag > lim) begin
                mag = lim;
                clip_hit = 1'b1;
            end
            return neg ? CW'(-mag) : CW'(mag);
        endfunction

        function iter_t iterate(point_t p);
            iter_t r;
            wide_t mx, my, mz, x2, y2, z2, s, den, dif, q, de, xm, ym, zm;
            logic nd, nq;
            mx = magnitude(p.x);
            my = magnitude(p.y);
            mz = magnitude(p.z);
            x2 = mx * mx;
            y2 = my * my;
            z2 = mz * mz;
            s  = x2 + y2;
            clip_hit = 1'b0;
            de = (wide_t'(p.de) * wide_t'(p.rad) * 2) >> FB;
            if (de > (wide_t'(1) << DE_W) - 1) begin
                de = (wide_t'(1) << DE_W) - 1;
                clip_hit = 1'b1;
            end
            r.de = DE_W'(de);
            if (s == 0) begin
                r.x = '0;
                r.y = '0;
                r.z = '0;
                r.on_axis = 1'b1;
            end else begin
                den = s << FB;
                nd  = s < z2;
                dif = nd ? z2 - s : s - z2;
                nq  = x2 < y2;
                q   = nq ? y2 - x2 : x2 - y2;
                xm  = (q * dif) / den;
                ym  = (mx * my * 2 * dif) / den;
                zm  = isqrt(z2 * 4 * s) >> FB;
                r.x = saturate(xm, (nq ^ nd) && xm != 0);
                r.y = saturate(ym, (p.x[CW-1] ^ p.y[CW-1] ^ nd) && ym != 0);
                // -2*z: positive z gives a negative result
                r.z = saturate(zm, mz != 0 && !p.z[CW-1] && zm != 0);
                r.on_axis = 1'b0;
            end
            r.clipped = clip_hit;
            return r;
        endfunction

        function void note_point(point_t p);
            expected_q.push_back(iterate(p));
        endfunction

        function void check_result(iter_t got);
            iter_t exp_r;
            if (expected_q.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected result item %h", got);
                return;
            end
            exp_r = expected_q.pop_front();
            if (got !== exp_r) begin
                errors++;
                if (errors <= 10)
                    $display("mismatch x %h/%h y %h/%h z %h/%h de %h/%h axis %b/%b clip %b/%b",
                             exp_r.x, got.x, exp_r.y, got.y, exp_r.z, got.z,
                             exp_r.de, got.de, exp_r.on_axis, got.on_axis,
                             exp_r.clipped, got.clipped);
            end
        endfunction
    endclass

    logic             aclk;
    logic             aresetn;
    logic             s_tvalid;
    logic             s_tready;
    logic [IN_W-1:0]  s_tdata;
    logic             m_tvalid;
    logic             m_tready;
    logic [OUT_W-1:0] m_tdata;
    logic [1:0]       m_tuser;

    iter_scoreboard sb;
    logic steady;
    int   quiet_cycles;

    mandelbulb_power2_iteration_top u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    initial begin
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        m_tready = 1'b0;
        steady   = 1'b0;
        quiet_cycles = 0;
        sb = new();
    end

    always @(posedge aclk) begin
        m_tready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            sb.check_result({m_tdata[CW-1:0], m_tdata[2*CW-1:CW], m_tdata[3*CW-1:2*CW],
                             m_tdata[OUT_W-1:3*CW], m_tuser[0], m_tuser[1]});
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !aresetn)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("mandelbulb_power2_iteration_top test failed");
            $finish;
        end
    end

    task automatic send_point(point_t p);
        if (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 2)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= p;
        do @(posedge aclk); while (!s_tready);
        sb.note_point(p);
    endtask

    function automatic logic [CW-1:0] rand_coord(int kind);
        case (kind)
            0:       return CW'($urandom_range(0, 1 << 19)) - CW'(1 << 18);
            1:       return CW'($urandom_range(0, 1 << 25)) - CW'(1 << 24);
            2:       return CW'($urandom_range(0, 16)) - CW'(8);
            default: return CW'($urandom);
        endcase
    endfunction

    function automatic point_t rand_point();
        point_t p;
        int kind;
        kind = $urandom_range(0, 9);
        p.x = rand_coord(kind < 5 ? 0 : kind < 7 ? 1 : kind == 9 ? 2 : 3);
        p.y = rand_coord(kind < 5 ? 0 : kind < 7 ? 1 : $urandom_range(0, 3));
        p.z = rand_coord(kind < 5 ? 0 : $urandom_range(0, 3));
        if (kind == 8) begin
            p.x = '0;
            p.y = '0;
        end
        p.de  = ($urandom_range(0, 3) == 0) ? DE_W'({$urandom, $urandom})
                                            : DE_W'($urandom_range(0, 1 << 22));
        p.rad = ($urandom_range(0, 3) == 0) ? RAD_W'($urandom)
                                            : RAD_W'($urandom_range(0, 1 << 19));
        return p;
    endfunction

    initial begin
        point_t dir_q[$];
        int wait_cycles;
        logic [CW-1:0] cmax, cmin, one;
        cmax = {1'b0, {(CW-1){1'b1}}};
        cmin = {1'b1, {(CW-1){1'b0}}};
        one  = CW'(1 << FB);

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // zero, on-axis, unit axes, extremes, saturation of de and coordinates
        dir_q.push_back('{rad: '0, de: '0, z: '0, y: '0, x: '0});
        dir_q.push_back('{rad: RAD_W'(2) << FB, de: DE_W'(1) << FB, z: one, y: '0, x: '0});
        dir_q.push_back('{rad: '1, de: '1, z: cmin, y: '0, x: '0});
        dir_q.push_back('{rad: one, de: DE_W'(1) << FB, z: '0, y: '0, x: one});
        dir_q.push_back('{rad: one, de: DE_W'(1) << FB, z: '0, y: one, x: '0});
        dir_q.push_back('{rad: one, de: DE_W'(3), z: one, y: -one, x: -one});
        dir_q.push_back('{rad: one, de: '0, z: -one, y: one, x: one});
        dir_q.push_back('{rad: '1, de: '1, z: cmax, y: cmax, x: cmax});
        dir_q.push_back('{rad: '1, de: '1, z: cmin, y: cmin, x: cmin});
        dir_q.push_back('{rad: '0, de: '1, z: cmin, y: cmax, x: cmin});
        dir_q.push_back('{rad: '1, de: '0, z: cmax, y: cmin, x: cmax});
        dir_q.push_back('{rad: RAD_W'(1), de: DE_W'(1), z: CW'(1), y: CW'(1), x: CW'(1)});
        dir_q.push_back('{rad: '0, de: '0, z: CW'(-1), y: CW'(-1), x: CW'(1)});
        dir_q.push_back('{rad: '0, de: '0, z: '0, y: CW'(1), x: '0});
        dir_q.push_back('{rad: '0, de: '0, z: cmax, y: CW'(1), x: '0});
        dir_q.push_back('{rad: '0, de: '0, z: CW'(3) << FB, y: one, x: one});
        dir_q.push_back('{rad: '0, de: '0, z: one, y: one << 6, x: one << 6});
        dir_q.push_back('{rad: '0, de: DE_W'(1) << 47, z: '0, y: '0, x: '0});
        dir_q.push_back('{rad: RAD_W'(1) << FB, de: DE_W'(1) << 47, z: '0, y: one, x: '0});
        foreach (dir_q[i]) send_point(dir_q[i]);

        for (int n = 0; n < N_RAND; n++) begin
            steady <= (n >= 300 && n < 500);
            send_point(rand_point());
        end
        s_tvalid <= 1'b0;
        steady   <= 1'b0;

        while (sb.expected_q.size() != 0) @(posedge aclk);
        wait_cycles = 0;
        while (wait_cycles < 100) begin
            @(posedge aclk);
            wait_cycles++;
        end

        if (sb.errors == 0 && sb.expected_q.size() == 0)
            $display("mandelbulb_power2_iteration_top test passed");
        else
            $display("mandelbulb_power2_iteration_top test failed");
        $finish;
    end

endmodule

/* filelist.f */
hdl/mbi_pkg.sv
hdl/mbi_dly.sv
hdl/mbi_mul.sv
hdl/mbi_div.sv
hdl/mbi_sqrt.sv
hdl/mbi_front.sv
hdl/mbi_queue.sv
hdl/mbi_back.sv
hdl/mandelbulb_power2_iteration_top.sv
hdl/mbi_check.sv
tb/tb_mandelbulb_power2_iteration_top.sv
